// ----- src/plr_pkg.sv -----
// Shared types and constants for the page-list range parser.
package plr_pkg;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_NUM1   = 3'd1,
      PH_AFTER1 = 3'd2,
      PH_DASH   = 3'd3,
      PH_NUM2   = 3'd4,
      PH_AFTER2 = 3'd5
   } phase_type;

   localparam logic [1:0] PAR_NONE = 2'd0;
   localparam logic [1:0] PAR_ODD  = 2'd1;
   localparam logic [1:0] PAR_EVEN = 2'd2;
   localparam logic [1:0] PAR_ALL  = 2'd3;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_E  = 8'h45;
   localparam logic [7:0] CH_UP_O  = 8'h4F;
   localparam logic [7:0] CH_LO_E  = 8'h65;
   localparam logic [7:0] CH_LO_O  = 8'h6F;

   localparam int RANGE_W = 22;
   localparam int PAGES_W = 20;
   localparam int TOTAL_W = 32;
   localparam int LIMIT_W = 20;

   typedef struct packed {
      logic signed [RANGE_W-1:0] first;
      logic signed [RANGE_W-1:0] last;
      logic [1:0]                mode;
      logic [PAGES_W-1:0]        pages;
      logic [TOTAL_W-1:0]        total;
   } range_out_type;

endpackage

// ----- src/plr_range.sv -----
// Parity alignment, ordering, clamping and page count for one finished element.
module plr_range #(
   parameter int PAGE_BITS = 20
) (
   input  logic signed [PAGE_BITS+1:0]    n1,
   input  logic signed [PAGE_BITS+1:0]    n2,
   input  logic [1:0]                     flags,
   input  logic [plr_pkg::LIMIT_W-1:0]    page_limit,
   input  logic [plr_pkg::TOTAL_W-1:0]    total,
   output plr_pkg::range_out_type         result
);
   import plr_pkg::*;

   localparam int SW    = PAGE_BITS + 2;
   localparam int SUM_W = TOTAL_W + 1;
   localparam logic signed [SW-1:0] ONE = SW'(1);
   localparam logic signed [SW-1:0] TWO = SW'(2);

   logic                 ge;
   logic                 adj1;
   logic                 adj2;
   logic signed [SW-1:0] a1;
   logic signed [SW-1:0] a2;
   logic signed [SW-1:0] lo;
   logic signed [SW-1:0] hi;
   logic signed [SW-1:0] lo_c;
   logic signed [SW-1:0] hi_c;
   logic signed [SW-1:0] lim_s;
   logic signed [SW-1:0] span;
   logic [SW-1:0]        half;
   logic [SW-1:0]        pages;
   logic                 has_lim;
   logic                 skip;
   logic [SUM_W-1:0]     sum;

   always_comb begin
      ge = (n2 >= n1);
      case (flags)
         PAR_EVEN: begin
            adj1 = n1[0];
            adj2 = n2[0];
         end
         PAR_ODD: begin
            adj1 = ~n1[0];
            adj2 = ~n2[0];
         end
         default: begin
            adj1 = 1'b0;
            adj2 = 1'b0;
         end
      endcase
      // move each endpoint inwards onto the parity, whichever way round the range is
      a1 = ge ? (n1 + SW'(adj1)) : (n1 - SW'(adj1));
      a2 = ge ? (n2 - SW'(adj2)) : (n2 + SW'(adj2));

      lo = (a1 < a2) ? a1 : a2;
      hi = (a1 < a2) ? a2 : a1;
      lim_s   = $signed(SW'(page_limit));
      has_lim = (page_limit != '0);
      skip    = (a1 <= 0 && a2 <= 0) || (has_lim && lo > lim_s) || (hi < ONE);
      lo_c = (lo < ONE) ? ONE : lo;
      hi_c = (has_lim && hi > lim_s) ? lim_s : hi;
      span = hi_c - lo_c;
      half = span + TWO;

      pages = '0;
      if (!skip) begin
         if (flags == PAR_ALL) begin
            pages = span + ONE;
         end else if (hi_c >= lo_c) begin
            pages = {1'b0, half[SW-1:1]};
         end
      end

      sum = {1'b0, total} + SUM_W'(pages);

      result.first = RANGE_W'(a1);
      result.last  = RANGE_W'(a2);
      result.mode  = (flags == PAR_ALL) ? PAR_NONE : flags;
      result.pages = PAGES_W'(pages);
      result.total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
   end

endmodule

// ----- src/page_list_range_parser.sv -----
// Page-list range parser: character-serial element parser with range arithmetic.
// A character beat taken sits in the input register; the result beat it finishes is loaded into
// the result register when the character is processed, which waits while the result side stalls.
// Throughput: one character per cycle while the result side does not stall.
// Reset (synchronous): parser state, running total, page limit and both valid flags clear;
// parity returns to all pages.
module page_list_range_parser #(
   parameter int PAGE_BITS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [plr_pkg::LIMIT_W-1:0]         csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_list_char,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_has_range,
   output logic signed [plr_pkg::RANGE_W-1:0]  rsp_range_first,
   output logic signed [plr_pkg::RANGE_W-1:0]  rsp_range_last,
   output logic [1:0]                          rsp_parity_mode,
   output logic [plr_pkg::PAGES_W-1:0]         rsp_range_pages,
   output logic [plr_pkg::TOTAL_W-1:0]         rsp_total_pages,
   output logic                                rsp_list_end
);
   import plr_pkg::*;

   localparam int SW = PAGE_BITS + 2;
   localparam logic [PAGE_BITS-1:0] PAGE_MAX = '1;
   localparam logic [LIMIT_W-1:0] LIM_MASK =
      (PAGE_BITS >= LIMIT_W) ? '1 : LIMIT_W'((64'd1 << PAGE_BITS) - 64'd1);
   localparam logic signed [SW-1:0] ONE_S   = SW'(1);
   localparam logic signed [SW-1:0] MINUS_1 = '1;

   function automatic logic [PAGE_BITS-1:0] acc_digit(input logic [PAGE_BITS-1:0] v,
                                                       input logic [3:0] d);
      logic [PAGE_BITS+3:0] t;
      t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (PAGE_BITS+4)'(d);
      return (t > (PAGE_BITS+4)'(PAGE_MAX)) ? PAGE_MAX : t[PAGE_BITS-1:0];
   endfunction

   // input stage
   logic       in_valid_ff;
   logic [7:0] in_char_ff;
   logic       adv;
   logic       process;

   // parser state
   phase_type            phase_ff, phase_in;
   logic [PAGE_BITS-1:0] first_value_ff, first_value_in;
   logic                 first_seen_ff, first_seen_in;
   logic [PAGE_BITS-1:0] second_value_ff, second_value_in;
   logic                 second_seen_ff, second_seen_in;
   logic [1:0]           parity_ff, parity_in;
   logic [TOTAL_W-1:0]   running_total_ff, running_total_in;
   logic                 list_started_ff, list_started_in;
   logic [LIMIT_W-1:0]   page_limit_ff;

   // decode
   logic                 is_end;
   logic                 dig;
   logic [3:0]           dval;
   logic [1:0]           mk;
   logic signed [SW-1:0] fv_s;
   logic signed [SW-1:0] sv_s;
   logic signed [SW-1:0] lim_s;
   logic signed [SW-1:0] n1_sel;

   // element finish
   logic                 fin;
   logic                 plain_end;
   logic signed [SW-1:0] fin_n1;
   logic signed [SW-1:0] fin_n2;
   logic [1:0]           fin_flags;
   range_out_type        rng;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_has_range_ff;
   logic signed [RANGE_W-1:0] rsp_first_ff;
   logic signed [RANGE_W-1:0] rsp_last_ff;
   logic [1:0]           rsp_mode_ff;
   logic [PAGES_W-1:0]   rsp_pages_ff;
   logic [TOTAL_W-1:0]   rsp_total_ff;
   logic                 rsp_end_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign process   = in_valid_ff && adv;
   assign req_stall = in_valid_ff && !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (process) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_list_char;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_limit_ff <= '0;
      end else if (csr_wr_en) begin
         page_limit_ff <= csr_wr_data & LIM_MASK;
      end
   end

   always_comb begin
      is_end = (in_char_ff == CH_NUL);
      dig    = (in_char_ff >= CH_ZERO) && (in_char_ff <= CH_NINE);
      dval   = dig ? 4'(in_char_ff - CH_ZERO) : 4'd0;
      if (in_char_ff == CH_LO_E || in_char_ff == CH_UP_E) begin
         mk = PAR_EVEN;
      end else if (in_char_ff == CH_LO_O || in_char_ff == CH_UP_O) begin
         mk = PAR_ODD;
      end else begin
         mk = PAR_NONE;
      end
      fv_s   = $signed(SW'(first_value_ff));
      sv_s   = $signed(SW'(second_value_ff));
      lim_s  = $signed(SW'(page_limit_ff));
      n1_sel = first_seen_ff ? fv_s : ONE_S;
   end

   always_comb begin
      phase_in         = phase_ff;
      first_value_in   = first_value_ff;
      first_seen_in    = first_seen_ff;
      second_value_in  = second_value_ff;
      second_seen_in   = second_seen_ff;
      parity_in        = parity_ff;
      running_total_in = running_total_ff;
      list_started_in  = !is_end;
      fin              = 1'b0;
      plain_end        = 1'b0;
      fin_n1           = fv_s;
      fin_n2           = fv_s;
      fin_flags        = parity_ff;

      case (phase_ff)
         PH_NUM1: begin
            if (dig) begin
               first_value_in = acc_digit(first_value_ff, dval);
            end else if (mk != PAR_NONE) begin
               parity_in = mk;
               phase_in  = PH_AFTER1;
            end else if (in_char_ff == CH_DASH) begin
               phase_in = PH_DASH;
            end else begin
               fin = 1'b1;
            end
         end
         PH_AFTER1: begin
            if (in_char_ff == CH_DASH) begin
               phase_in = PH_DASH;
            end else begin
               fin = 1'b1;
               if (!first_seen_ff) begin
                  // bare marker: whole document
                  fin_n1 = ONE_S;
                  fin_n2 = lim_s;
               end
            end
         end
         PH_DASH: begin
            if (mk != PAR_NONE) begin
               parity_in      = mk;
               second_seen_in = 1'b0;
               phase_in       = PH_AFTER2;
            end else if (dig) begin
               second_value_in = PAGE_BITS'(dval);
               second_seen_in  = 1'b1;
               phase_in        = PH_NUM2;
            end else begin
               fin    = 1'b1;
               fin_n1 = n1_sel;
               fin_n2 = lim_s;
            end
         end
         PH_NUM2: begin
            if (dig) begin
               second_value_in = acc_digit(second_value_ff, dval);
            end else if (mk != PAR_NONE) begin
               parity_in = mk;
               phase_in  = PH_AFTER2;
            end else begin
               fin    = 1'b1;
               fin_n1 = n1_sel;
               fin_n2 = sv_s;
            end
         end
         PH_AFTER2: begin
            fin    = 1'b1;
            fin_n1 = n1_sel;
            fin_n2 = second_seen_ff ? sv_s : lim_s;
         end
         default: begin
            // element start, also taken for codes with no meaning
            phase_in        = PH_START;
            first_value_in  = '0;
            first_seen_in   = 1'b0;
            second_value_in = '0;
            second_seen_in  = 1'b0;
            parity_in       = PAR_ALL;
            fin_flags       = PAR_ALL;
            if (is_end) begin
               plain_end = 1'b1;
            end else if (mk != PAR_NONE) begin
               parity_in = mk;
               phase_in  = PH_AFTER1;
            end else if (dig) begin
               first_value_in = PAGE_BITS'(dval);
               first_seen_in  = 1'b1;
               phase_in       = PH_NUM1;
            end else if (in_char_ff == CH_DASH) begin
               phase_in = PH_DASH;
            end else begin
               // empty element
               fin    = 1'b1;
               fin_n1 = MINUS_1;
               fin_n2 = MINUS_1;
            end
         end
      endcase

      if (fin || plain_end) begin
         phase_in        = PH_START;
         first_value_in  = '0;
         first_seen_in   = 1'b0;
         second_value_in = '0;
         second_seen_in  = 1'b0;
         parity_in       = PAR_ALL;
         if (fin) begin
            running_total_in = rng.total;
         end
         if (is_end) begin
            running_total_in = '0;
         end
      end
   end

   plr_range #(
      .PAGE_BITS (PAGE_BITS)
   ) u_range (
      .n1         (fin_n1),
      .n2         (fin_n2),
      .flags      (fin_flags),
      .page_limit (page_limit_ff),
      .total      (running_total_ff),
      .result     (rng)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_START;
         first_value_ff   <= '0;
         first_seen_ff    <= 1'b0;
         second_value_ff  <= '0;
         second_seen_ff   <= 1'b0;
         parity_ff        <= PAR_ALL;
         running_total_ff <= '0;
         list_started_ff  <= 1'b0;
      end else if (process) begin
         phase_ff         <= phase_in;
         first_value_ff   <= first_value_in;
         first_seen_ff    <= first_seen_in;
         second_value_ff  <= second_value_in;
         second_seen_ff   <= second_seen_in;
         parity_ff        <= parity_in;
         running_total_ff <= running_total_in;
         list_started_ff  <= list_started_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (process && (fin || plain_end)) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (process && fin) begin
         rsp_has_range_ff <= 1'b1;
         rsp_first_ff     <= rng.first;
         rsp_last_ff      <= rng.last;
         rsp_mode_ff      <= rng.mode;
         rsp_pages_ff     <= rng.pages;
         rsp_total_ff     <= rng.total;
         rsp_end_ff       <= is_end;
      end else if (process && plain_end) begin
         rsp_has_range_ff <= 1'b0;
         rsp_first_ff     <= '0;
         rsp_last_ff      <= '0;
         rsp_mode_ff      <= PAR_NONE;
         rsp_pages_ff     <= '0;
         rsp_total_ff     <= list_started_ff ? running_total_ff : TOTAL_W'(page_limit_ff);
         rsp_end_ff       <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_has_range   = rsp_has_range_ff;
   assign rsp_range_first = rsp_first_ff;
   assign rsp_range_last  = rsp_last_ff;
   assign rsp_parity_mode = rsp_mode_ff;
   assign rsp_range_pages = rsp_pages_ff;
   assign rsp_total_pages = rsp_total_ff;
   assign rsp_list_end    = rsp_end_ff;

   // a beat without an element only comes from the terminator
   a_bare_is_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_has_range) |-> rsp_list_end)
      else $error("result without element not flagged as list end");

   a_pages_need_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_pages != '0) |-> rsp_has_range)
      else $error("pages reported without an element");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (process && in_char_ff == CH_NUL) |=>
         (running_total_ff == '0 && phase_ff == PH_START && !list_started_ff))
      else $error("terminator did not restart the list");

   a_total_grows: assert property (@(posedge clock) disable iff (reset)
      (process && in_char_ff != CH_NUL) |=> (running_total_ff >= $past(running_total_ff)))
      else $error("running total fell within a list");

   a_parity_valid: assert property (@(posedge clock) disable iff (reset)
      parity_ff != PAR_NONE)
      else $error("parity flags lost");

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the page-list range parser: random page lists, scoreboard, handshakes.
module testbench;
   import plr_pkg::*;

   localparam int     PAGE_BITS = 20;
   localparam longint PAGE_MAX  = (64'd1 << PAGE_BITS) - 1;
   localparam longint TOTAL_MAX = 64'h0000_0000_FFFF_FFFF;
   localparam int     PHASE_CHARS = 150;
   localparam int     HOLD_CYCLES = 300;

   typedef struct {
      logic                      has_range;
      logic signed [RANGE_W-1:0] first_page;
      logic signed [RANGE_W-1:0] last_page;
      logic [1:0]                mode;
      logic [PAGES_W-1:0]        pages;
      logic [TOTAL_W-1:0]        total;
      logic                      list_end;
   } page_result_type;

   // Tracks the parser state per accepted character and holds the ranges still owed.
   class range_checker;
      bit [LIMIT_W-1:0] limit;
      phase_type        phase;
      bit [LIMIT_W-1:0] first_val;
      bit               first_seen;
      bit [LIMIT_W-1:0] second_val;
      bit               second_seen;
      bit [1:0]         par;
      bit [TOTAL_W-1:0] total;
      bit               started;
      page_result_type  due_ranges[$];
      int               faults;

      function new();
         limit = '0;
         faults = 0;
         clear_all();
      endfunction

      function void clear_element();
         phase = PH_START;
         first_val = '0;
         first_seen = 1'b0;
         second_val = '0;
         second_seen = 1'b0;
         par = PAR_ALL;
      endfunction

      function void clear_all();
         clear_element();
         total = '0;
         started = 1'b0;
      endfunction

      function void set_limit(bit [LIMIT_W-1:0] v);
         limit = v & LIMIT_W'(PAGE_MAX);
      endfunction

      function bit [LIMIT_W-1:0] grow(bit [LIMIT_W-1:0] v, bit [LIMIT_W-1:0] d);
         longint t;
         t = longint'(v) * 10 + longint'(d);
         return (t > PAGE_MAX) ? LIMIT_W'(PAGE_MAX) : t[LIMIT_W-1:0];
      endfunction

      function page_result_type close_element(longint n1, longint n2, bit nul);
         longint lim, lo, hi, pages, sum;
         page_result_type r;
         lim = limit;
         pages = 0;
         // parity alignment pulls both ends inwards, whichever way round they are
         if (par == PAR_EVEN) begin
            if (n2 >= n1) begin
               if (n1[0]) n1 += 1;
               if (n2[0]) n2 -= 1;
            end else begin
               if (n1[0]) n1 -= 1;
               if (n2[0]) n2 += 1;
            end
         end else if (par == PAR_ODD) begin
            if (n2 >= n1) begin
               if (!n1[0]) n1 += 1;
               if (!n2[0]) n2 -= 1;
            end else begin
               if (!n1[0]) n1 -= 1;
               if (!n2[0]) n2 += 1;
            end
         end
         if (!(n1 <= 0 && n2 <= 0)) begin
            lo = (n1 < n2) ? n1 : n2;
            hi = (n1 < n2) ? n2 : n1;
            if (!((lim > 0 && lo > lim) || hi < 1)) begin
               if (lo < 1) lo = 1;
               if (lim > 0 && hi > lim) hi = lim;
               if (par == PAR_ALL) pages = hi - lo + 1;
               else if (hi >= lo) pages = (hi - lo + 2) / 2;
            end
         end
         sum = longint'(total) + pages;
         total = (sum > TOTAL_MAX) ? '1 : sum[TOTAL_W-1:0];
         r.has_range = 1'b1;
         r.first_page = n1[RANGE_W-1:0];
         r.last_page = n2[RANGE_W-1:0];
         r.mode = (par == PAR_ALL) ? PAR_NONE : par;
         r.pages = pages[PAGES_W-1:0];
         r.total = total;
         r.list_end = nul;
         if (nul) clear_all();
         else clear_element();
         return r;
      endfunction

      function void take_char(bit [7:0] c);
         bit nul, was_started, dig, made;
         bit [1:0] mk;
         bit [LIMIT_W-1:0] d;
         longint lim, n1, n2;
         page_result_type r;
         nul = (c == CH_NUL);
         was_started = started;
         if (c == CH_LO_E || c == CH_UP_E) mk = PAR_EVEN;
         else if (c == CH_LO_O || c == CH_UP_O) mk = PAR_ODD;
         else mk = PAR_NONE;
         dig = (c >= CH_ZERO && c <= CH_NINE);
         d = dig ? LIMIT_W'(c - CH_ZERO) : '0;
         lim = limit;
         n1 = first_seen ? longint'(first_val) : 1;
         made = 1'b0;
         if (!nul) started = 1'b1;
         case (phase)
            PH_NUM1: begin
               if (dig) first_val = grow(first_val, d);
               else if (mk != PAR_NONE) begin
                  par = mk;
                  phase = PH_AFTER1;
               end else if (c == CH_DASH) phase = PH_DASH;
               else begin
                  r = close_element(first_val, first_val, nul);
                  made = 1'b1;
               end
            end
            PH_AFTER1: begin
               if (c == CH_DASH) phase = PH_DASH;
               else begin
                  // bare marker means the whole book
                  n2 = first_seen ? longint'(first_val) : lim;
                  r = close_element(n1, n2, nul);
                  made = 1'b1;
               end
            end
            PH_DASH: begin
               if (mk != PAR_NONE) begin
                  par = mk;
                  second_seen = 1'b0;
                  phase = PH_AFTER2;
               end else if (dig) begin
                  second_val = d;
                  second_seen = 1'b1;
                  phase = PH_NUM2;
               end else begin
                  r = close_element(n1, lim, nul);
                  made = 1'b1;
               end
            end
            PH_NUM2: begin
               if (dig) second_val = grow(second_val, d);
               else if (mk != PAR_NONE) begin
                  par = mk;
                  phase = PH_AFTER2;
               end else begin
                  r = close_element(n1, second_val, nul);
                  made = 1'b1;
               end
            end
            PH_AFTER2: begin
               n2 = second_seen ? longint'(second_val) : lim;
               r = close_element(n1, n2, nul);
               made = 1'b1;
            end
            default: begin
               clear_element();
               if (nul) begin
                  r = '{default: 0};
                  r.total = was_started ? total : TOTAL_W'(limit);
                  r.list_end = 1'b1;
                  clear_all();
                  made = 1'b1;
               end else if (mk != PAR_NONE) begin
                  par = mk;
                  phase = PH_AFTER1;
               end else if (dig) begin
                  first_val = d;
                  first_seen = 1'b1;
                  phase = PH_NUM1;
               end else if (c == CH_DASH) phase = PH_DASH;
               else begin
                  r = close_element(-1, -1, 1'b0);
                  made = 1'b1;
               end
            end
         endcase
         if (made) due_ranges.push_back(r);
      endfunction

      function void same_field(string name, logic signed [63:0] want, logic signed [63:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            faults++;
         end
      endfunction

      function void check_range(page_result_type got);
         page_result_type want;
         if (due_ranges.size() == 0) begin
            $error("result beat with nothing owed: total_pages %0d", got.total);
            faults++;
         end else begin
            want = due_ranges.pop_front();
            same_field("has_range", want.has_range, got.has_range);
            same_field("range_first", want.first_page, got.first_page);
            same_field("range_last", want.last_page, got.last_page);
            same_field("parity_mode", want.mode, got.mode);
            same_field("range_pages", want.pages, got.pages);
            same_field("total_pages", want.total, got.total);
            same_field("list_end", want.list_end, got.list_end);
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      csr_wr_en = 1'b0;
   logic [LIMIT_W-1:0]        csr_wr_data = '0;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [7:0]                req_list_char = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_has_range;
   logic signed [RANGE_W-1:0] rsp_range_first;
   logic signed [RANGE_W-1:0] rsp_range_last;
   logic [1:0]                rsp_parity_mode;
   logic [PAGES_W-1:0]        rsp_range_pages;
   logic [TOTAL_W-1:0]        rsp_total_pages;
   logic                      rsp_list_end;

   range_checker    board = new();
   page_result_type seen_range;
   bit [7:0]        list_chars[$];
   int              cur_limit = 0;
   int              send_idle_pct = 0;
   int              stall_pct = 0;
   bit              hold_req = 1'b0;

   page_list_range_parser #(.PAGE_BITS(PAGE_BITS)) i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_list_char   (req_list_char),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_has_range   (rsp_has_range),
      .rsp_range_first (rsp_range_first),
      .rsp_range_last  (rsp_range_last),
      .rsp_parity_mode (rsp_parity_mode),
      .rsp_range_pages (rsp_range_pages),
      .rsp_total_pages (rsp_total_pages),
      .rsp_list_end    (rsp_list_end)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // beat monitor: everything sampled at the edge, before the edge's updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen_range.has_range = rsp_has_range;
            seen_range.first_page = rsp_range_first;
            seen_range.last_page = rsp_range_last;
            seen_range.mode = rsp_parity_mode;
            seen_range.pages = rsp_range_pages;
            seen_range.total = rsp_total_pages;
            seen_range.list_end = rsp_list_end;
            board.check_range(seen_range);
         end
         if (req_valid && !req_stall) board.take_char(req_list_char);
         if (csr_wr_en) board.set_limit(csr_wr_data);
      end
   end

   // result side: random stall, or a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic send_char(bit [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_list_char <= c;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.due_ranges.size() != 0) @(posedge clock);
      // characters that finish nothing may still sit in the pipe
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(int v);
      csr_wr_data <= LIMIT_W'(v);
      csr_wr_en <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_limit = v;
   endtask

   task automatic add_number();
      int cap;
      string s;
      cap = (cur_limit == 0) ? 3000 : cur_limit + 3;
      case ($urandom_range(9))
         0: s = $sformatf("%0d%0d", $urandom_range(99999, 10000), $urandom_range(99999));
         1: s = $urandom_range(1) ? "0" : "00";
         2: s = $sformatf("0%0d", $urandom_range(cap));
         3, 4, 5: s = $sformatf("%0d", $urandom_range(cap));
         default: s = $sformatf("%0d", $urandom_range(12, 1));
      endcase
      for (int i = 0; i < s.len(); i++) list_chars.push_back(s[i]);
   endtask

   task automatic add_marker();
      case ($urandom_range(3))
         0: list_chars.push_back(CH_LO_O);
         1: list_chars.push_back(CH_UP_O);
         2: list_chars.push_back(CH_LO_E);
         default: list_chars.push_back(CH_UP_E);
      endcase
   endtask

   task automatic add_side();
      int k;
      k = $urandom_range(9);
      if (k == 2) add_marker();
      else if (k >= 3) begin
         add_number();
         if (k == 7 || k == 8) add_marker();
      end
   endtask

   task automatic add_separator();
      bit [7:0] c;
      if ($urandom_range(9) < 7) c = ",";
      else begin
         do c = 8'($urandom_range(255, 1));
         while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_DASH || c == CH_LO_E ||
                c == CH_UP_E || c == CH_LO_O || c == CH_UP_O);
      end
      list_chars.push_back(c);
   endtask

   task automatic build_list();
      int n;
      string pool;
      pool = "0123456789-oeOE,";
      list_chars.delete();
      if ($urandom_range(9) == 0) begin
         // noise, NULs included
         n = $urandom_range(12, 1);
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(1)) list_chars.push_back(8'($urandom_range(255)));
            else list_chars.push_back(pool[$urandom_range(15)]);
         end
      end else begin
         n = $urandom_range(4);
         for (int i = 0; i < n; i++) begin
            add_side();
            if ($urandom_range(9) < 6) begin
               list_chars.push_back(CH_DASH);
               add_side();
            end
            if (i < n - 1 || $urandom_range(1)) add_separator();
         end
      end
      list_chars.push_back(CH_NUL);
   endtask

   task automatic run_phase(int lim, int send_pct, int recv_pct, bit squeeze);
      int count;
      count = 0;
      write_limit(lim);
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
      if (squeeze) hold_req = 1'b1;
      while (count < PHASE_CHARS) begin
         build_list();
         foreach (list_chars[i]) begin
            send_char(list_chars[i]);
            count++;
         end
      end
      drain();
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty list with no limit, then the named corner cases at a small limit
      write_limit(0);
      send_char(CH_NUL);
      drain();
      write_limit(20);
      send_text(",o,7-3e");
      send_char(CH_NUL);
      send_text("2o-6e,");
      send_char(CH_NUL);
      send_text("99999999-");
      send_char(CH_NUL);
      drain();

      run_phase(int'(PAGE_MAX), 0, 0, 1'b0);
      run_phase(1, 69, 0, 1'b0);
      run_phase($urandom_range(200, 2), 0, 69, 1'b0);
      run_phase(0, 25, 25, 1'b0);
      run_phase($urandom_range(int'(PAGE_MAX), 1), 0, 0, 1'b1);
      run_phase(50, 25, 25, 1'b0);

      repeat (10) @(posedge clock);
      if (board.faults == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
